// File: rtl/core/pqfd_pkg.sv
// ----------------------------------------------------------------------------
// pqfd_pkg
// Shared types and constants for the position and quaternion frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pqfd_pkg;

   localparam int STORE_DEPTH = 15;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] FRAME_GROUP = 4'd15;
   localparam logic [3:0] FRAME_PLAIN = 4'd14;
   localparam logic [3:0] ADDR_INDEX  = 4'd14;
   localparam int         PHASE_BIT   = 7;

   localparam logic [15:0] WORD_MIN = 16'h8000;
   localparam logic [15:0] WORD_MAX = 16'h7fff;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic                          group;
      byte_type [STORE_DEPTH-1:0]    bytes;
   } frame_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      byte_type           sensor_address;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/pqfd_front.sv
// ----------------------------------------------------------------------------
// pqfd_front
// Hunts for the phasing bit, collects frame bytes and hands finished frames on.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [0:0]         csr_data,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output pqfd_pkg::frame_type     push_frame
);

   logic                                         group_mode_ff;
   logic                                         group_mode_in;
   logic [3:0]                                   count_ff;
   logic [3:0]                                   count_in;
   pqfd_pkg::byte_type [pqfd_pkg::STORE_DEPTH-1:0] store_ff;
   pqfd_pkg::byte_type [pqfd_pkg::STORE_DEPTH-1:0] store_in;
   logic [3:0]                                   frame_len;
   logic                                         accept;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign frame_len  = group_mode_ff ? pqfd_pkg::FRAME_GROUP : pqfd_pkg::FRAME_PLAIN;
   assign group_mode_in = (csr_valid && csr_ready) ? csr_data[0] : group_mode_ff;

   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      if (accept) begin
         if (count_ff == 4'd0) begin
            if (req_tdata[pqfd_pkg::PHASE_BIT]) begin
               store_in[0] = req_tdata;
               count_in    = 4'd1;
            end
         end else begin
            if (count_ff < 4'(pqfd_pkg::STORE_DEPTH)) begin
               store_in[count_ff] = req_tdata;
            end
            count_in = 4'(count_ff + 4'd1);
         end
         if (count_in >= frame_len) begin
            push_valid = 1'b1;
            count_in   = 4'd0;
         end
      end
   end

   assign push_frame.group = group_mode_ff;
   assign push_frame.bytes = store_in;

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (reset) begin
         group_mode_ff <= 1'b0;
         count_ff      <= 4'd0;
      end else begin
         group_mode_ff <= group_mode_in;
         count_ff      <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < pqfd_pkg::FRAME_GROUP)
      else $error("Byte count passed the longest frame.");

   a_push_started: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != 4'd0 || pqfd_pkg::FRAME_PLAIN == 4'd1))
      else $error("Frame completed without a started frame.");

endmodule

`default_nettype wire

// File: rtl/core/pqfd_queue.sv
// ----------------------------------------------------------------------------
// pqfd_queue
// Two-entry frame queue that decouples frame collection from decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire pqfd_pkg::frame_type  push_frame,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output pqfd_pkg::frame_type       pop_frame
);

   pqfd_pkg::frame_type entry_ff [pqfd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = count_ff != 2'(pqfd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != 2'd0;
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(pqfd_pkg::QUEUE_DEPTH))
      else $error("Frame queue count overflow.");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(pqfd_pkg::QUEUE_DEPTH)) |->
      (wr_ptr_ff == rd_ptr_ff))
      else $error("Frame queue pointers disagree with count.");

endmodule

`default_nettype wire

// File: rtl/core/pqfd_back.sv
// ----------------------------------------------------------------------------
// pqfd_back
// Decodes a queued frame into position and quaternion words and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire pqfd_pkg::frame_type  pop_frame,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output pqfd_pkg::result_type      rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   pqfd_pkg::result_type result_ff;
   pqfd_pkg::result_type result_in;
   logic [15:0]          w_raw;

   function automatic logic [15:0] word_at(input pqfd_pkg::byte_type lo,
                                           input pqfd_pkg::byte_type hi);
      return {hi[6:0], lo[6:0], 2'b00};
   endfunction

   assign pop_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      w_raw = word_at(pop_frame.bytes[6], pop_frame.bytes[7]);
      result_in.pos_x  = word_at(pop_frame.bytes[0], pop_frame.bytes[1]);
      result_in.pos_y  = word_at(pop_frame.bytes[2], pop_frame.bytes[3]);
      result_in.pos_z  = word_at(pop_frame.bytes[4], pop_frame.bytes[5]);
      result_in.quat_x = word_at(pop_frame.bytes[8], pop_frame.bytes[9]);
      result_in.quat_y = word_at(pop_frame.bytes[10], pop_frame.bytes[11]);
      result_in.quat_z = word_at(pop_frame.bytes[12], pop_frame.bytes[13]);
      if (w_raw == pqfd_pkg::WORD_MIN) begin
         result_in.quat_w = pqfd_pkg::WORD_MAX;
      end else begin
         result_in.quat_w = 16'(~w_raw + 16'd1);
      end
      result_in.sensor_address = pop_frame.group ?
                                 pop_frame.bytes[pqfd_pkg::ADDR_INDEX] : 8'd0;
      valid_in = pop_ready ? pop_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         result_ff <= result_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> rsp_tvalid)
      else $error("Decoded frame was not presented.");

endmodule

`default_nettype wire

// File: rtl/core/position_quaternion_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// position_quaternion_frame_decoder_core
// Frames a tracker byte stream and reports position and quaternion words.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req_     in         tdata[7:0] data_byte
//  rsp_     out        tdata[119:0] pos_x..quat_w, sensor_address
//  csr_     in         data[0] group_mode
//
//  One byte is accepted every cycle while the two-entry frame queue has room.
//  A finished frame is registered in the frame queue, then in the output register.
//  Reset clears the byte count, group_mode and the queue; frame bytes are not cleared.
//  A stalled result holds in the output register; bytes arrive until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module position_quaternion_frame_decoder_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // data_byte
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [119:0]       rsp_tdata,   // pos_x, pos_y, pos_z, quat_x, quat_y,
                                           // quat_z, quat_w, sensor_address
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [0:0]    csr_data
);

   logic                 push_valid;
   logic                 push_ready;
   pqfd_pkg::frame_type  push_frame;
   logic                 pop_valid;
   logic                 pop_ready;
   pqfd_pkg::frame_type  pop_frame;
   pqfd_pkg::result_type rsp_result;

   pqfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame)
   );

   pqfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   pqfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.sensor_address, rsp_result.quat_w,
                       rsp_result.quat_z, rsp_result.quat_y, rsp_result.quat_x,
                       rsp_result.pos_z, rsp_result.pos_y, rsp_result.pos_x};

endmodule

`default_nettype wire
